>>> hdl/dmm_pkg.sv
// Shared constants and types for the dense matrix multiplier.
// No dependencies; imported by dmm_ram users and the top level.
`timescale 1ns / 1ps
`default_nettype none
package dmm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + DIM_W;
  localparam int SHIFT_W    = ACC_W - FRAC_BITS;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] ACT_WRITE_A = 2'd0;
  localparam logic [1:0] ACT_WRITE_B = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic             first;
    logic             fin;
    logic             last;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } tag_t;

  // Dimension register holds (dim - 1), with 0 taken as 1 and large values as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - 1'b1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/dense_matrix_multiply.sv
// Dense Q16.16 matrix multiplier top level: A and B stores, MAC pipeline, output stage.
// Depends on dmm_pkg and dmm_ram.
//
// Element writes are accepted whenever busy is low. A compute request runs one
// multiply-accumulate per cycle through a single shared MAC fed by the A and B memories,
// over a_rows * inner_dim * b_cols products, through the pipeline steps memory read,
// multiply, accumulate and saturate. Results leave on out_valid_o for one cycle each in
// row-major order, one per completed inner_dim accumulation; the receiver cannot stall
// them. busy drops with the last result.
`timescale 1ns / 1ps
`default_nettype none
module dense_matrix_multiply
  import dmm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [1:0]           action_i,
  input  wire logic [DIM_W-1:0]     elem_row_i,
  input  wire logic [DIM_W-1:0]     elem_col_i,
  input  wire logic signed [DATA_W-1:0] elem_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output      logic                 out_valid_o,
  output      logic [DIM_W-1:0]     out_row_o,
  output      logic [DIM_W-1:0]     out_col_o,
  output      logic signed [DATA_W-1:0] out_value_o,
  output      logic                 saturated_o,
  output      logic                 last_o
);

  logic [DIM_W-1:0] rmax_q, kmax_q, cmax_q;
  logic busy_q, busy_d;
  logic run_q, run_d;
  logic [DIM_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;

  logic accept, wr_a, wr_b;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  logic s1_v_q, s2_v_q, s3_v_q;
  tag_t s0_tag, s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [SHIFT_W-1:0] shifted;
  logic [DATA_W-1:0] sat_value;
  logic sat_flag;

  logic out_valid_q;
  logic [DIM_W-1:0] out_row_q, out_col_q;
  logic [DATA_W-1:0] out_value_q;
  logic out_sat_q, out_last_q;

  assign accept = start && !busy_q;
  assign waddr  = {elem_row_i, elem_col_i};
  assign wr_a   = accept && (action_i == ACT_WRITE_A);
  assign wr_b   = accept && (action_i == ACT_WRITE_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmax_q <= '0;
      kmax_q <= '0;
      cmax_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A_ROWS:    rmax_q <= clamp_dim(cfg_data_i);
        REG_INNER_DIM: kmax_q <= clamp_dim(cfg_data_i);
        REG_B_COLS:    cmax_q <= clamp_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  dmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  dmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Index sequencer: k innermost, then column, then row.
  assign a_raddr = {r_q, k_q};
  assign b_raddr = {k_q, c_q};

  always_comb begin
    s0_tag.first = (k_q == '0);
    s0_tag.fin   = (k_q == kmax_q);
    s0_tag.last  = (k_q == kmax_q) && (c_q == cmax_q) && (r_q == rmax_q);
    s0_tag.row   = r_q;
    s0_tag.col   = c_q;
  end

  always_comb begin
    run_d  = run_q;
    r_d    = r_q;
    c_d    = c_q;
    k_d    = k_q;
    busy_d = busy_q;
    if (accept && (action_i == ACT_COMPUTE)) begin
      run_d  = 1'b1;
      busy_d = 1'b1;
      r_d    = '0;
      c_d    = '0;
      k_d    = '0;
    end else if (run_q) begin
      if (k_q != kmax_q) begin
        k_d = k_q + 1'b1;
      end else begin
        k_d = '0;
        if (c_q != cmax_q) begin
          c_d = c_q + 1'b1;
        end else begin
          c_d = '0;
          if (r_q != rmax_q) begin
            r_d = r_q + 1'b1;
          end else begin
            run_d = 1'b0;
          end
        end
      end
    end
    if (s3_v_q && s3_tag_q.fin && s3_tag_q.last) begin
      busy_d = 1'b0;
    end
  end

  // Accumulate, then floor-shift and saturate.
  assign acc_d   = s2_tag_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
  assign shifted = SHIFT_W'(acc_q >>> FRAC_BITS);

  always_comb begin
    sat_flag  = 1'b0;
    sat_value = shifted[DATA_W-1:0];
    if (shifted[SHIFT_W-1:DATA_W-1] != {(SHIFT_W-DATA_W+1){shifted[SHIFT_W-1]}}) begin
      sat_flag  = 1'b1;
      sat_value = shifted[SHIFT_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      run_q       <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      run_q       <= run_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      s1_v_q      <= run_q;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      out_valid_q <= s3_v_q && s3_tag_q.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= s0_tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= $signed(a_rdata) * $signed(b_rdata);
    if (s2_v_q) begin
      s3_tag_q <= s2_tag_q;
      acc_q    <= acc_d;
    end
    out_row_q   <= s3_tag_q.row;
    out_col_q   <= s3_tag_q.col;
    out_value_q <= sat_value;
    out_sat_q   <= sat_flag;
    out_last_q  <= s3_tag_q.last;
  end

  assign busy        = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

endmodule
`default_nettype wire
